@@ src/eec_pkg.sv @@
// Shared constants and types for the elastic easing curve pipeline.
// No dependencies; imported by eec_term and elastic_easing_curve.
package eec_pkg;

  localparam int TERM_W = 32;  // series term and multiplier operand width
  localparam int SUM_W  = 34;  // signed series accumulator width
  localparam int FRAC_Q = 30;  // curve, exp2 and sine fraction bits

  localparam logic [TERM_W-1:0] ONE_Q30   = 32'h4000_0000;
  localparam logic [31:0]       LN2_Q32   = 32'd2977044472;
  // pi/2 in Q32 minus 2^32
  localparam logic [31:0]       HALFPI_LO = 32'd2451551556;

  localparam logic [1:0] MODE_IN  = 2'd0;
  localparam logic [1:0] MODE_OUT = 2'd1;
  localparam logic [1:0] MODE_IO  = 2'd2;

  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_DURATION = 2'd1;
  localparam logic [1:0] REG_START    = 2'd2;
  localparam logic [1:0] REG_CHANGE   = 2'd3;

  localparam logic [3:0] CDIV_IO   = 4'd9;
  localparam logic [3:0] CDIV_EDGE = 4'd3;

  typedef enum logic [1:0] {
    K_START,
    K_END,
    K_CURVE
  } kind_t;

endpackage

@@ src/elastic_easing_curve.sv @@
// Elastic easing curve: start + change * curve(step / duration), Q16.16.
// Top level; uses eec_pkg and eec_term.
//
// Fully pipelined: one step is taken on every cycle in which start is high and
// busy is low. Its result is strobed on out_valid. The pipeline holds the
// 33-stage restoring divider for step / duration and the 13-term exp2 series
// at three stages per term. Results cannot be held off: out_valid lasts one
// cycle. busy is high only in reset. Registers are written through the cfg
// port, which is always ready; change them only while no step is in flight.
module elastic_easing_curve #(
  parameter int STEP_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_time_step,
  output logic               out_valid,
  output logic signed [31:0] out_eased_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import eec_pkg::*;

  localparam int SW       = (STEP_BITS < 16) ? STEP_BITS : 16;
  localparam int QW       = 33;
  localparam int CD_STG   = 2;
  localparam int EX_N     = 13;
  localparam int SN_N     = 7;
  localparam int SR_N     = 3 * EX_N;
  localparam int SD_N     = 3 * (EX_N - SN_N);
  localparam int TL_N     = 6;

  // floor(2^33 / 9) and floor(2^32 / 3)
  localparam logic [31:0] RCP_IO   = 32'd954437176;
  localparam logic [31:0] RCP_EDGE = 32'd1431655765;

  typedef struct packed {
    kind_t      kind;
    logic       inout_m;
    logic       neg;
    logic [3:0] ei;
    logic       sneg;
  } side_t;

  function automatic logic [30:0] clamp_q30(input logic signed [SUM_W-1:0] s);
    logic [30:0] c;
    if (s < 0) begin
      c = '0;
    end else if (s > $signed({{(SUM_W-TERM_W){1'b0}}, ONE_Q30})) begin
      c = ONE_Q30[30:0];
    end else begin
      c = s[30:0];
    end
    return c;
  endfunction

  // configuration
  logic [1:0]         mode_r;
  logic [15:0]        dur_r;
  logic signed [31:0] start_r, change_r;
  logic               busy_r;
  logic               accept;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;
  assign accept    = start & ~busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b1;
      mode_r   <= MODE_IO;
      dur_r    <= 16'd100;
      start_r  <= '0;
      change_r <= 32'sd65536;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_MODE:     mode_r   <= cfg_data[1:0];
          REG_DURATION: dur_r    <= cfg_data[15:0];
          REG_START:    start_r  <= $signed(cfg_data);
          REG_CHANGE:   change_r <= $signed(cfg_data);
          default:      ;
        endcase
      end
    end
  end

  // entry and divider: q = (t << 33) / d
  logic [SW-1:0] t_m, d_m;
  side_t         a_side;

  assign t_m = in_time_step[SW-1:0];
  assign d_m = dur_r[SW-1:0];

  logic          dv_v    [0:QW];
  side_t         dv_side [0:QW];
  logic [SW-1:0] dv_rem  [0:QW];
  logic [QW-1:0] dv_q    [0:QW];

  always_comb begin
    a_side         = '0;
    a_side.inout_m = !(mode_r == MODE_IN || mode_r == MODE_OUT);
    if (t_m == '0) begin
      a_side.kind = K_START;
    end else if (t_m >= d_m) begin
      a_side.kind = K_END;
    end else begin
      a_side.kind = K_CURVE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    dv_side[0] <= a_side;
    dv_rem[0]  <= t_m;
    dv_q[0]    <= '0;
  end

  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [SW:0] rem2;
    logic        ge;
    always_comb begin
      rem2 = {dv_rem[i], 1'b0};
      ge   = rem2 >= {1'b0, d_m};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v[i+1] <= 1'b0;
      end else begin
        dv_v[i+1] <= dv_v[i];
      end
    end
    always_ff @(posedge clk) begin
      dv_side[i+1] <= dv_side[i];
      dv_rem[i+1]  <= ge ? SW'(rem2 - {1'b0, d_m}) : rem2[SW-1:0];
      dv_q[i+1]    <= {dv_q[i][QW-2:0], ge};
    end
  end

  // distance w from the curve's knee, then floor(2w/9) or floor(w/3)
  logic        cd_v    [0:CD_STG];
  side_t       cd_side [0:CD_STG];
  logic [31:0] cd_w    [0:CD_STG];

  logic [32:0] wq;
  logic        wneg;
  side_t       w_side;

  always_comb begin
    w_side = dv_side[QW];
    if (dv_side[QW].inout_m) begin
      wneg = ~dv_q[QW][32];
      wq   = wneg ? 33'h1_0000_0000 - dv_q[QW] : dv_q[QW] - 33'h1_0000_0000;
    end else begin
      wneg = (mode_r == MODE_IN);
      wq   = wneg ? 33'h1_0000_0000 - {1'b0, dv_q[QW][32:1]} : {1'b0, dv_q[QW][32:1]};
    end
    w_side.neg = wneg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_v[0] <= 1'b0;
    end else begin
      cd_v[0] <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    cd_side[0] <= w_side;
    cd_w[0]    <= wq[31:0];
  end

  for (genvar j = 0; j < CD_STG; j++) begin : g_cdiv
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cd_v[j+1] <= 1'b0;
      end else begin
        cd_v[j+1] <= cd_v[j];
      end
    end
    always_ff @(posedge clk) begin
      cd_side[j+1] <= cd_side[j];
      cd_w[j+1]    <= cd_w[j];
    end
  end

  // reciprocal estimate is exact or one low, then one correction step
  logic [63:0] cq_p;
  logic [31:0] cq_q0_r, cq_q_r;
  logic [33:0] cq_x, cq_m, cq_rem, cq_k;

  always_comb begin
    cq_p   = 64'(cd_w[0]) * 64'(cd_side[0].inout_m ? RCP_IO : RCP_EDGE);
    cq_x   = cd_side[1].inout_m ? {1'b0, cd_w[1], 1'b0} : {2'b0, cd_w[1]};
    cq_m   = cd_side[1].inout_m ? ({2'b0, cq_q0_r} << 3) + {2'b0, cq_q0_r}
                                : ({2'b0, cq_q0_r} << 1) + {2'b0, cq_q0_r};
    cq_rem = cq_x - cq_m;
    cq_k   = cd_side[1].inout_m ? {30'b0, CDIV_IO} : {30'b0, CDIV_EDGE};
  end

  always_ff @(posedge clk) begin
    cq_q0_r <= cq_p[63:32];
    cq_q_r  <= (cq_rem >= cq_k) ? cq_q0_r + 32'd1 : cq_q0_r;
  end

  // phase and exp argument
  logic [31:0] quo, dsc, psg, phase;
  logic [35:0] e36;
  side_t       e_nside;
  logic        e_v, f_v, g_v;
  side_t       e_side, f_side, g_side;
  logic [31:0] e_phase, e_ef;

  always_comb begin
    quo = cq_q_r;
    if (cd_side[CD_STG].inout_m) begin
      dsc = {cd_w[CD_STG][30:0], 1'b0} + quo;
    end else begin
      dsc = {cd_w[CD_STG][30:0], 1'b0} + cd_w[CD_STG] + quo;
    end
    psg     = cd_side[CD_STG].neg ? 32'd0 - dsc : dsc;
    phase   = psg - 32'h4000_0000;
    e36     = ({4'b0, cd_w[CD_STG]} << 3) + ({4'b0, cd_w[CD_STG]} << 1);
    e_nside = cd_side[CD_STG];
    e_nside.ei = e36[35:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
    end else begin
      e_v <= cd_v[CD_STG];
      f_v <= e_v;
      g_v <= f_v;
    end
  end

  logic [63:0] pf, pg, ph;
  logic [30:0] rf;
  side_t       f_nside;
  logic [29:0] f_xe, g_xe, h_xe;
  logic [30:0] f_r, g_xs, h_xs;
  logic [31:0] h_x2;

  always_comb begin
    pf = 64'(e_ef) * 64'(LN2_Q32);
    rf = e_phase[30] ? 31'h4000_0000 - {1'b0, e_phase[29:0]} : {1'b0, e_phase[29:0]};
    f_nside = e_side;
    f_nside.sneg = e_phase[31];
    pg = 64'(f_r) * 64'(HALFPI_LO);
    ph = 64'(g_xs) * 64'(g_xs);
  end

  always_ff @(posedge clk) begin
    e_side  <= e_nside;
    e_phase <= phase;
    e_ef    <= e36[31:0];
    f_side  <= f_nside;
    f_xe    <= pf[63:34];
    f_r     <= rf;
    g_side  <= f_side;
    g_xe    <= f_xe;
    g_xs    <= f_r + pg[62:32];
    h_xe    <= g_xe;
    h_xs    <= g_xs;
    h_x2    <= ph[61:30];
  end

  // series
  logic                     sr_v    [0:SR_N];
  side_t                    sr_side [0:SR_N];
  logic [TERM_W-1:0]        ex_term [0:EX_N];
  logic [TERM_W-1:0]        ex_mul  [0:EX_N];
  logic signed [SUM_W-1:0]  ex_sum  [0:EX_N];
  logic [TERM_W-1:0]        sn_term [0:SN_N];
  logic [TERM_W-1:0]        sn_mul  [0:SN_N];
  logic signed [SUM_W-1:0]  sn_sum  [0:SN_N];
  logic signed [SUM_W-1:0]  sd      [0:SD_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_v[0] <= 1'b0;
    end else begin
      sr_v[0] <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    sr_side[0] <= g_side;
  end

  assign ex_term[0] = ONE_Q30;
  assign ex_mul[0]  = {2'b0, h_xe};
  assign ex_sum[0]  = $signed({{(SUM_W-TERM_W){1'b0}}, ONE_Q30});
  assign sn_term[0] = {1'b0, h_xs};
  assign sn_mul[0]  = h_x2;
  assign sn_sum[0]  = $signed({{(SUM_W-31){1'b0}}, h_xs});

  for (genvar k = 1; k <= EX_N; k++) begin : g_exp
    eec_term #(.K_DIV(k), .SUB((k % 2) == 1)) u_term (
      .clk    (clk),
      .term_i (ex_term[k-1]),
      .mul_i  (ex_mul[k-1]),
      .sum_i  (ex_sum[k-1]),
      .term_o (ex_term[k]),
      .mul_o  (ex_mul[k]),
      .sum_o  (ex_sum[k])
    );
  end

  for (genvar k = 1; k <= SN_N; k++) begin : g_sin
    eec_term #(.K_DIV((2 * k) * (2 * k + 1)), .SUB((k % 2) == 1)) u_term (
      .clk    (clk),
      .term_i (sn_term[k-1]),
      .mul_i  (sn_mul[k-1]),
      .sum_i  (sn_sum[k-1]),
      .term_o (sn_term[k]),
      .mul_o  (sn_mul[k]),
      .sum_o  (sn_sum[k])
    );
  end

  for (genvar i = 0; i < SR_N; i++) begin : g_sr
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sr_v[i+1] <= 1'b0;
      end else begin
        sr_v[i+1] <= sr_v[i];
      end
    end
    always_ff @(posedge clk) begin
      sr_side[i+1] <= sr_side[i];
    end
  end

  assign sd[0] = sn_sum[SN_N];

  for (genvar i = 0; i < SD_N; i++) begin : g_sd
    always_ff @(posedge clk) begin
      sd[i+1] <= sd[i];
    end
  end

  // combine and scale
  logic               tv    [1:TL_N];
  side_t              tside [1:TL_N];
  logic [30:0]        i_ex, sclamp;
  logic signed [31:0] i_sn;
  logic signed [63:0] j_gs, gadj;
  logic signed [31:0] k_gs;
  logic signed [32:0] gse, l_f;
  logic signed [64:0] m_p, nadj;
  logic signed [34:0] n_r;

  localparam logic signed [63:0] HALF_30 = 64'sd1073741824;
  localparam logic signed [63:0] HALF_29 = 64'sd536870912;
  localparam logic signed [64:0] HALF_P  = 65'sd536870912;

  always_comb begin
    sclamp = clamp_q30(sd[SD_N]);
    gadj   = j_gs + (tside[2].inout_m ? HALF_30 : HALF_29) - 64'(j_gs[63]);
    gse    = 33'(k_gs);
    nadj   = m_p + HALF_P - 65'(m_p[64]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= TL_N; i++) begin
        tv[i] <= 1'b0;
      end
    end else begin
      tv[1] <= sr_v[SR_N];
      for (int i = 1; i < TL_N; i++) begin
        tv[i+1] <= tv[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    tside[1] <= sr_side[SR_N];
    for (int i = 1; i < TL_N; i++) begin
      tside[i+1] <= tside[i];
    end
    i_ex <= clamp_q30(ex_sum[EX_N]) >> sr_side[SR_N].ei;
    i_sn <= sr_side[SR_N].sneg ? -$signed({1'b0, sclamp}) : $signed({1'b0, sclamp});
    j_gs <= $signed({1'b0, i_ex}) * i_sn;
    k_gs <= tside[2].inout_m ? gadj[62:31] : gadj[61:30];
    l_f  <= tside[3].neg ? -gse : 33'sh4000_0000 + gse;
    m_p  <= change_r * l_f;
    n_r  <= nadj[64:30];
  end

  // final add and saturation
  logic signed [34:0] opd;
  logic signed [35:0] fsum;
  logic signed [31:0] res;
  logic               out_v_r;
  logic signed [31:0] out_val_r;

  always_comb begin
    opd  = (tside[TL_N].kind == K_END) ? 35'(change_r) : n_r;
    fsum = 36'(start_r) + 36'(opd);
    if (tside[TL_N].kind == K_START) begin
      res = start_r;
    end else if (fsum > 36'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (fsum < -36'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = fsum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= tv[TL_N];
    end
  end

  always_ff @(posedge clk) begin
    out_val_r <= res;
  end

  assign out_valid       = out_v_r;
  assign out_eased_value = out_val_r;

  a_tail_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    tv[TL_N] |=> out_v_r)
    else $error("result strobe missing after final stage");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> busy_r)
    else $error("busy low right after reset");

  a_start_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (tv[TL_N] && tside[TL_N].kind == K_START) |=> (out_val_r == $past(start_r)))
    else $error("zero step did not return start value");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !tv[TL_N] |=> !out_v_r)
    else $error("result strobe without a step in the final stage");

endmodule

@@ src/eec_term.sv @@
// One Taylor series term: term = ((term * mul) >> 30) / K_DIV, added to or
// subtracted from the running sum. Three register stages. Uses eec_pkg.
module eec_term #(
  parameter int K_DIV = 1,
  parameter bit SUB   = 1'b0
) (
  input  logic                               clk,
  input  logic [eec_pkg::TERM_W-1:0]         term_i,
  input  logic [eec_pkg::TERM_W-1:0]         mul_i,
  input  logic signed [eec_pkg::SUM_W-1:0]   sum_i,
  output logic [eec_pkg::TERM_W-1:0]         term_o,
  output logic [eec_pkg::TERM_W-1:0]         mul_o,
  output logic signed [eec_pkg::SUM_W-1:0]   sum_o
);
  import eec_pkg::*;

  localparam longint unsigned RECIP_L = (64'd1 << TERM_W) / K_DIV;
  localparam logic [TERM_W-1:0] RECIP = TERM_W'(RECIP_L);
  localparam logic [TERM_W-1:0] KD    = TERM_W'(K_DIV);

  logic [2*TERM_W-1:0]      p1;
  logic [TERM_W-1:0]        s1_y_r, s1_mul_r;
  logic signed [SUM_W-1:0]  s1_sum_r;
  logic [TERM_W-1:0]        q0;
  logic [TERM_W-1:0]        s2_y_r, s2_q0_r, s2_mul_r;
  logic signed [SUM_W-1:0]  s2_sum_r;
  logic [TERM_W-1:0]        rem, qn;

  assign p1 = term_i * mul_i;

  always_ff @(posedge clk) begin
    s1_y_r   <= p1[FRAC_Q +: TERM_W];
    s1_mul_r <= mul_i;
    s1_sum_r <= sum_i;
  end

  // reciprocal estimate is exact or one low
  if (K_DIV == 1) begin : g_unit
    assign q0 = s1_y_r;
  end else begin : g_recip
    logic [2*TERM_W-1:0] p2;
    assign p2 = s1_y_r * RECIP;
    assign q0 = p2[2*TERM_W-1:TERM_W];
  end

  always_ff @(posedge clk) begin
    s2_y_r   <= s1_y_r;
    s2_q0_r  <= q0;
    s2_mul_r <= s1_mul_r;
    s2_sum_r <= s1_sum_r;
  end

  always_comb begin
    rem = s2_y_r - s2_q0_r * KD;
    qn  = (rem >= KD) ? s2_q0_r + 1'b1 : s2_q0_r;
  end

  always_ff @(posedge clk) begin
    term_o <= qn;
    mul_o  <= s2_mul_r;
    if (SUB) begin
      sum_o <= s2_sum_r - $signed({{(SUM_W-TERM_W){1'b0}}, qn});
    end else begin
      sum_o <= s2_sum_r + $signed({{(SUM_W-TERM_W){1'b0}}, qn});
    end
  end

endmodule
